// ===== sv/pic_pkg.sv =====
// shared types and constants for the point-in-convex-polygon block
// no dependencies; used by pic_xprod_unit, point_in_convex_polygon_top and the testbench
package pic_pkg;

  localparam int unsigned COORD_W = 16;             // offsets, positions, points
  localparam int unsigned ABS_W   = COORD_W + 1;    // position plus offset
  localparam int unsigned DIF_W   = COORD_W + 2;    // difference of two absolute values
  localparam int unsigned PROD_W  = 2 * DIF_W;      // one exact product
  localparam int unsigned XP_W    = PROD_W + 1;     // difference of two products

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_CFG_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // stream word layout
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // control of the shared cross-product unit
  typedef struct packed {
    logic mul_en;   // capture a new product
    logic acc_en;   // move the held product into the accumulator
  } xp_ctrl_t;

endpackage

// ===== sv/point_in_convex_polygon_top.sv =====
// point-in-convex-polygon test: sequencer, config registers and output register
// depends on pic_pkg, pic_vtx_mem and pic_xprod_unit
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser op, tdata index, x, y
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata inside_res
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// a vertex write leaves the sequencer in idle; a query walks the edges, passes its
//   result word to the output register from the done state and then returns to idle
//   (count of zero: straight from idle to the done state)
// each edge goes through a difference load, two multiplies on the single
//   shared multiplier, one compare; the table read of the next edge end overlaps
//   the compare; a query stops at the first failing edge
// the input side is ready only in idle; a finished result waits in the done
//   state while the output register is still full
// reset clears control and configuration; the vertex table is not cleared
module point_in_convex_polygon_top #(
  parameter int unsigned MAX_VERTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: vertex_index [3:0], coord_x [19:4], coord_y [35:20], zero pad [39:36]
  input  logic [pic_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: op
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: inside_res [0], zero pad [7:1]
  output logic [pic_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pic_pkg::COORD_W-1:0]       cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_VERTS + 1);
  localparam int unsigned CW1   = CNT_W + 1;
  localparam int unsigned CW    = pic_pkg::COORD_W;
  localparam int unsigned AW_   = pic_pkg::ABS_W;
  localparam int unsigned DW_   = pic_pkg::DIF_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;  // first vertex arrives from the table
  localparam logic [2:0] ST_LOAD  = 3'd2;  // edge end arrives, form differences
  localparam logic [2:0] ST_MUL1  = 3'd3;  // ex * dy
  localparam logic [2:0] ST_MUL2  = 3'd4;  // ey * dx
  localparam logic [2:0] ST_CMP   = 3'd5;  // sign of the cross product
  localparam logic [2:0] ST_DONE  = 3'd6;  // result waits for the output register

  // input word fields
  logic [3:0]           in_index;
  logic signed [CW-1:0] in_x;
  logic signed [CW-1:0] in_y;
  assign in_index = s_axis_tdata[3:0];
  assign in_x     = s_axis_tdata[19:4];
  assign in_y     = s_axis_tdata[35:20];

  // configuration
  logic signed [CW-1:0]              pos_x_q, pos_y_q;
  logic [pic_pkg::CNT_CFG_W-1:0]     count_q;
  logic [CNT_W-1:0]                  n_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pic_pkg::REG_POS_X: pos_x_q <= cfg_data_i;
        pic_pkg::REG_POS_Y: pos_y_q <= cfg_data_i;
        pic_pkg::REG_COUNT: count_q <= cfg_data_i[pic_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // count above the table depth is clamped
  assign n_eff = (32'(count_q) > 32'(MAX_VERTS)) ? CNT_W'(MAX_VERTS) : CNT_W'(count_q);

  // sequencer registers
  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         edge_q, edge_d;
  logic                     result_q, result_d;
  logic signed [CW-1:0]     pt_x_q, pt_y_q;
  logic signed [AW_-1:0]    prev_x_q, prev_y_q;
  logic signed [DW_-1:0]    ex_q, ey_q, dx_q, dy_q;
  logic                     out_valid_q;
  logic                     out_inside_q;

  logic                     in_acc;
  logic                     out_free;
  logic [CW1-1:0]           e1, e2;
  logic                     last_edge;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [2*CW-1:0]          rd_data;
  logic signed [CW-1:0]     rd_x, rd_y;
  logic signed [AW_-1:0]    cur_x, cur_y;
  pic_pkg::xp_ctrl_t        xp_ctrl;
  logic signed [DW_-1:0]    op_a, op_b;
  logic                     xp_pos;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign e1        = CW1'(edge_q) + CW1'(1);
  assign e2        = CW1'(edge_q) + CW1'(2);
  assign last_edge = (e1 == CW1'(n_eff));

  // vertex table writes: slots past the table depth are dropped
  assign wr_en = in_acc && (s_axis_tuser == pic_pkg::OP_WRITE) &&
                 (32'(in_index) < 32'(MAX_VERTS));

  assign rd_x  = rd_data[CW-1:0];
  assign rd_y  = rd_data[2*CW-1:CW];
  assign cur_x = AW_'(pos_x_q) + AW_'(rd_x);
  assign cur_y = AW_'(pos_y_q) + AW_'(rd_y);

  always_comb begin
    state_d  = state_q;
    edge_d   = edge_q;
    result_d = result_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    xp_ctrl  = '0;
    op_a     = ex_q;
    op_b     = dy_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == pic_pkg::OP_QUERY)) begin
          edge_d = '0;
          if (n_eff == '0) begin
            // empty polygon counts as inside
            result_d = 1'b1;
            state_d  = ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        // fetch the end of edge zero, wrapping for a single vertex
        rd_en   = 1'b1;
        rd_addr = last_edge ? '0 : IDX_W'(e1);
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        xp_ctrl.mul_en = 1'b1;
        op_a           = ex_q;
        op_b           = dy_q;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        xp_ctrl.mul_en = 1'b1;
        xp_ctrl.acc_en = 1'b1;
        op_a           = ey_q;
        op_b           = dx_q;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        if (!xp_pos) begin
          result_d = 1'b0;
          state_d  = ST_DONE;
        end else if (last_edge) begin
          result_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          edge_d  = IDX_W'(e1);
          rd_en   = 1'b1;
          rd_addr = (e2 == CW1'(n_eff)) ? '0 : IDX_W'(e2);
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      edge_q      <= '0;
      result_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      edge_q   <= edge_d;
      result_q <= result_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_x_q <= in_x;
      pt_y_q <= in_y;
    end
    if (state_q == ST_FIRST) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if (state_q == ST_LOAD) begin
      ex_q     <= DW_'(cur_x) - DW_'(prev_x_q);
      ey_q     <= DW_'(cur_y) - DW_'(prev_y_q);
      dx_q     <= DW_'(pt_x_q) - DW_'(prev_x_q);
      dy_q     <= DW_'(pt_y_q) - DW_'(prev_y_q);
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_inside_q <= result_q;
    end
  end

  pic_vtx_mem #(
    .DEPTH (MAX_VERTS),
    .AW    (IDX_W),
    .DW    (2 * CW)
  ) u_vtx_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (IDX_W'(in_index)),
    .wdata_i ({in_y, in_x}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pic_xprod_unit u_xprod (
    .clk_i  (clk_i),
    .ctrl_i (xp_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .pos_o  (xp_pos)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(pic_pkg::OUT_DATA_W-1){1'b0}}, out_inside_q};

  // a query on a non-empty polygon starts by fetching vertex zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == pic_pkg::OP_QUERY) && (n_eff != '0))
      |=> (state_q == ST_FIRST))
    else $error("query did not start the edge walk");

  // the second multiply always follows the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL1) |=> (state_q == ST_MUL2))
    else $error("cross product sequence broken");

  // the edge index stays inside the polygon during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIRST) || (state_q == ST_LOAD) || (state_q == ST_MUL1) ||
     (state_q == ST_MUL2) || (state_q == ST_CMP)) |-> (CW1'(edge_q) < CW1'(n_eff)))
    else $error("edge index past vertex count");

  // a result word only appears from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word without a finished query");

endmodule

// ===== sv/pic_vtx_mem.sv =====
// vertex offset table: one write port, one registered read port
// no package dependency; instantiated by point_in_convex_polygon_top
module pic_vtx_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pic_xprod_unit.sv =====
// shared multiplier with product and accumulator registers
// depends on pic_pkg; one edge cross product takes two multiplies
module pic_xprod_unit (
  input  logic                                clk_i,
  input  pic_pkg::xp_ctrl_t                   ctrl_i,
  input  logic signed [pic_pkg::DIF_W-1:0]    op_a_i,
  input  logic signed [pic_pkg::DIF_W-1:0]    op_b_i,
  output logic                                pos_o
);

  logic signed [pic_pkg::PROD_W-1:0] prod_q;
  logic signed [pic_pkg::PROD_W-1:0] acc_q;
  logic signed [pic_pkg::XP_W-1:0]   diff;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= op_a_i * op_b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= prod_q;
    end
  end

  // first product minus second, strictly positive
  assign diff  = pic_pkg::XP_W'(acc_q) - pic_pkg::XP_W'(prod_q);
  assign pos_o = !diff[pic_pkg::XP_W-1] && (diff != '0);

endmodule

// ===== tb/sv/tb_point_in_convex_polygon_top.sv =====
// self-checking testbench for point_in_convex_polygon_top: vertex table loads, queries
// and polygon config, checked against an inside/outside predictor kept in a small class
// depends on pic_pkg and the rtl of point_in_convex_polygon_top
`timescale 1ns / 1ps

// predicts the inside flag of every query and keeps the expected flags in order
class polygon_scoreboard;
  localparam int unsigned SLOTS = 16;

  // copy of the vertex table and of the config registers
  int          vert_x [SLOTS];
  int          vert_y [SLOTS];
  int          origin_x;
  int          origin_y;
  int unsigned verts_in_use;

  bit          inside_fifo [$];
  int unsigned n_queries;
  int unsigned n_inside;
  int unsigned n_results;
  int unsigned n_errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      vert_x[i] = 0;
      vert_y[i] = 0;
    end
    origin_x     = 0;
    origin_y     = 0;
    verts_in_use = 0;
    n_queries    = 0;
    n_inside     = 0;
    n_results    = 0;
    n_errors     = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      pic_pkg::REG_POS_X: origin_x = int'($signed(data));
      pic_pkg::REG_POS_Y: origin_y = int'($signed(data));
      pic_pkg::REG_COUNT: verts_in_use = data[4:0];
      default: ;
    endcase
  endfunction

  // strictly positive cross product on every edge, walked in table order
  function bit point_inside(int px, int py);
    int unsigned n;
    int unsigned j;
    longint      ax, ay, bx, by, cr;
    n = (verts_in_use > SLOTS) ? SLOTS : verts_in_use;
    for (int unsigned i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ax = longint'(origin_x) + vert_x[i];
      ay = longint'(origin_y) + vert_y[i];
      bx = longint'(origin_x) + vert_x[j];
      by = longint'(origin_y) + vert_y[j];
      cr = (bx - ax) * (longint'(py) - ay) - (by - ay) * (longint'(px) - ax);
      if (cr <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_item(logic op, logic [3:0] slot, logic [15:0] x, logic [15:0] y);
    bit want;
    if (op == pic_pkg::OP_WRITE) begin
      if (slot < SLOTS) begin
        vert_x[slot] = int'($signed(x));
        vert_y[slot] = int'($signed(y));
      end
    end else begin
      want = point_inside(int'($signed(x)), int'($signed(y)));
      inside_fifo.insert(inside_fifo.size(), want);
      n_queries++;
      if (want) n_inside++;
    end
  endfunction

  function void check_inside(logic got);
    bit want;
    n_results++;
    if (inside_fifo.size() == 0) begin
      n_errors++;
      if (n_errors <= 10)
        $display("result word %0d arrived with no query pending, inside_res=%0b",
                 n_results, got);
      return;
    end
    want = inside_fifo.pop_front();
    if (got !== want) begin
      n_errors++;
      if (n_errors <= 10)
        $display("inside_res mismatch on result word %0d: expected %0b, got %0b",
                 n_results, want, got);
    end
  endfunction

  function int unsigned pending();
    return inside_fifo.size();
  endfunction
endclass

module tb_point_in_convex_polygon_top;

  localparam int unsigned VERT_SLOTS   = 16;
  localparam int unsigned ITEM_TARGET  = 1850;
  // longest query walks every edge of a full table, plus the output register, with margin
  localparam int unsigned DRAIN_CYCLES = 100;
  // receiver hold-off that backs the block up into its input
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // register index that the block does not decode
  localparam logic [pic_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  // tdata: vertex_index [3:0], coord_x [19:4], coord_y [35:20], zero pad [39:36]
  logic [pic_pkg::IN_DATA_W-1:0]   s_axis_tdata;
  // tuser: op
  logic                            s_axis_tuser;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // tdata: inside_res [0], zero pad [7:1]
  logic [pic_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [pic_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [pic_pkg::COORD_W-1:0]     cfg_data_i;

  polygon_scoreboard polygon_sb;

  // run statistics and idling modes shared between the processes
  int unsigned items_sent   = 0;
  int unsigned n_writes     = 0;
  int unsigned n_reg_writes = 0;
  int unsigned n_setups     = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_no_gap    = 1'b0;
  bit          rx_no_stall  = 1'b0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  point_in_convex_polygon_top #(
    .MAX_VERTS(VERT_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // offers one word on the input stream and waits for it to be taken
  task automatic push_item(input logic op, input logic [3:0] slot, input int x, input int y);
    int gap;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, y[15:0], x[15:0], slot};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    polygon_sb.note_item(op, slot, x[15:0], y[15:0]);
    items_sent++;
    if (op == pic_pkg::OP_WRITE) n_writes++;
    gap = tx_no_gap ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // one config write; valid drops for a cycle between writes
  task automatic program_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    polygon_sb.write_reg(idx, data);
    n_reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering, wait for every pending result, then let a trailing
  // vertex write or query finish inside the block
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (polygon_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // field extremes, empty and single-vertex polygons, points on a vertex and
  // on an edge, position extremes, count with junk upper bits, the undecoded
  // register and a clockwise triangle
  task automatic directed_part();
    // reset leaves count at zero: empty polygon reports inside
    push_item(pic_pkg::OP_QUERY, 4'hf, -32768, 32767);
    push_item(pic_pkg::OP_WRITE, 4'hf, 32767, 32767);
    push_item(pic_pkg::OP_WRITE, 4'h0, 32767, -32768);
    settle_block();
    program_reg(pic_pkg::REG_COUNT, 16'd1);
    // single vertex gives one zero-length edge
    push_item(pic_pkg::OP_QUERY, 4'h0, 0, 0);
    // counterclockwise triangle spanning the full offset range
    push_item(pic_pkg::OP_WRITE, 4'd0, -32768, -32768);
    push_item(pic_pkg::OP_WRITE, 4'd1, 32767, -32768);
    push_item(pic_pkg::OP_WRITE, 4'd2, 0, 32767);
    settle_block();
    // only the low five bits count: this is three
    program_reg(pic_pkg::REG_COUNT, 16'hffe3);
    push_item(pic_pkg::OP_QUERY, 4'd0, 0, 0);
    push_item(pic_pkg::OP_QUERY, 4'd1, -32768, -32768);   // on a vertex
    push_item(pic_pkg::OP_QUERY, 4'd2, 0, -32768);        // on the bottom edge
    push_item(pic_pkg::OP_QUERY, 4'd3, 32767, 32767);
    settle_block();
    // position at the extremes pushes vertices to 17 bits
    program_reg(pic_pkg::REG_POS_X, 16'h7fff);
    program_reg(pic_pkg::REG_POS_Y, 16'h8000);
    push_item(pic_pkg::OP_QUERY, 4'd0, 32767, -32768);
    push_item(pic_pkg::OP_QUERY, 4'd0, -32768, 32767);
    settle_block();
    program_reg(pic_pkg::REG_POS_X, 16'h8000);
    program_reg(pic_pkg::REG_POS_Y, 16'h8000);
    push_item(pic_pkg::OP_QUERY, 4'd5, -32768, -32768);
    settle_block();
    // undecoded register must leave the polygon alone
    program_reg(REG_UNUSED, 16'hffff);
    push_item(pic_pkg::OP_QUERY, 4'd5, -32768, -32768);
    // swap two vertices: clockwise triangle, nothing is inside
    push_item(pic_pkg::OP_WRITE, 4'd1, 0, 32767);
    push_item(pic_pkg::OP_WRITE, 4'd2, 32767, -32768);
    push_item(pic_pkg::OP_QUERY, 4'd5, -32768, -32768);
  endtask

  // one polygon setup: config, vertex table load, then a burst of queries
  task automatic run_phase();
    int          cnt, n, r, pick, shape, slope, t, k, j, nq, px, py;
    int          co_x, co_y, cabs_x, cabs_y, pos_x, pos_y;
    int          vx [VERT_SLOTS];
    int          vy [VERT_SLOTS];
    real         theta0, ang, jit;
    bit          backward;
    logic [15:0] cnt_data;

    // vertex count: mostly small, a few full tables and counts past the table
    pick = $urandom_range(0, 99);
    if (pick < 4)       cnt = 0;
    else if (pick < 9)  cnt = $urandom_range(1, 2);
    else if (pick < 80) cnt = $urandom_range(3, 8);
    else if (pick < 92) cnt = $urandom_range(9, 16);
    else                cnt = $urandom_range(17, 31);
    n = (cnt > VERT_SLOTS) ? VERT_SLOTS : cnt;

    pick = $urandom_range(0, 99);
    if (pick < 30)      r = $urandom_range(4, 100);
    else if (pick < 75) r = $urandom_range(100, 4000);
    else if (pick < 92) r = $urandom_range(4000, 16000);
    else                r = $urandom_range(16000, 30000);
    co_x = rand_between(-(32767 - r), 32767 - r);
    co_y = rand_between(-(32767 - r), 32767 - r);

    // keep the polygon reachable by 16-bit points, except at extreme positions
    if ($urandom_range(0, 9) == 0) begin
      pos_x = $urandom_range(0, 1) ? 32767 : -32768;
      pos_y = $urandom_range(0, 1) ? 32767 : -32768;
    end else begin
      cabs_x = rand_between(-32767 + r, 32767 - r);
      cabs_y = rand_between(-32767 + r, 32767 - r);
      pos_x  = clamp16(cabs_x - co_x);
      pos_y  = clamp16(cabs_y - co_y);
      co_x   = cabs_x - pos_x;
      co_y   = cabs_y - pos_y;
    end
    cabs_x = pos_x + co_x;
    cabs_y = pos_y + co_y;

    // convex ccw on a circle, convex cw, scattered junk, or all on one line
    shape  = $urandom_range(0, 99);
    theta0 = $urandom_range(0, 6283) / 1000.0;
    slope  = rand_between(-1, 1);
    for (k = 0; k < n; k++) begin
      if (shape < 80) begin
        jit = ($urandom_range(0, 800) / 1000.0) - 0.4;
        ang = 6.283185307179586 * (k + jit) / n;
        ang = (shape < 68) ? theta0 + ang : theta0 - ang;
        vx[k] = co_x + int'(r * $cos(ang));
        vy[k] = co_y + int'(r * $sin(ang));
      end else if (shape < 90) begin
        vx[k] = co_x + rand_between(-r, r);
        vy[k] = co_y + rand_between(-r, r);
      end else begin
        t = rand_between(-r, r);
        vx[k] = co_x + t;
        vy[k] = co_y + slope * t;
      end
    end

    settle_block();
    tx_no_gap   = ($urandom_range(0, 4) == 0);
    rx_no_stall = ($urandom_range(0, 4) == 0);
    program_reg(pic_pkg::REG_POS_X, pos_x[15:0]);
    program_reg(pic_pkg::REG_POS_Y, pos_y[15:0]);
    cnt_data = 16'(cnt);
    if ($urandom_range(0, 4) == 0) cnt_data[15:5] = 11'($urandom);
    program_reg(pic_pkg::REG_COUNT, cnt_data);
    if ($urandom_range(0, 9) == 0) program_reg(REG_UNUSED, 16'($urandom));

    // every slot the queries read is loaded first, in either order
    backward = $urandom_range(0, 1);
    for (k = 0; k < n; k++) begin
      j = backward ? n - 1 - k : k;
      push_item(pic_pkg::OP_WRITE, 4'(j), vx[j], vy[j]);
    end
    if (n < VERT_SLOTS && $urandom_range(0, 2) == 0)
      push_item(pic_pkg::OP_WRITE, 4'($urandom_range(n, VERT_SLOTS - 1)),
                rand_between(-32768, 32767), rand_between(-32768, 32767));

    nq = (n > 8) ? $urandom_range(3, 8) : $urandom_range(10, 24);
    for (int q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        px = cabs_x + rand_between(-r - r / 4, r + r / 4);
        py = cabs_y + rand_between(-r - r / 4, r + r / 4);
      end else if (pick < 50 && n > 0) begin
        k  = $urandom_range(0, n - 1);
        px = pos_x + vx[k];
        py = pos_y + vy[k];
      end else if (pick < 60 && n > 0) begin
        // edge midpoint, exactly on the edge when the sums are even
        k  = $urandom_range(0, n - 1);
        j  = (k + 1 == n) ? 0 : k + 1;
        px = pos_x + (vx[k] + vx[j]) / 2;
        py = pos_y + (vy[k] + vy[j]) / 2;
      end else if (pick < 70) begin
        px = cabs_x + rand_between(-2, 2);
        py = cabs_y + rand_between(-2, 2);
      end else if (pick < 85) begin
        px = rand_between(-32768, 32767);
        py = rand_between(-32768, 32767);
      end else begin
        px = $urandom_range(0, 1) ? 32767 : -32768;
        py = $urandom_range(0, 1) ? 32767 : -32768;
      end
      push_item(pic_pkg::OP_QUERY, 4'($urandom), clamp16(px), clamp16(py));
    end
    n_setups++;
  endtask

  // receive side: random stalls, and twice a long hold-off while the
  // sender is still offering so that the block backs up into its input
  initial begin : result_sink
    int          stall;
    int unsigned holds_done;
    stall         = 0;
    holds_done    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done < 2 && s_axis_tvalid &&
          results_seen >= ((holds_done == 0) ? 100 : 700)) begin
        m_axis_tready <= 1'b0;
        holds_done++;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_no_stall) begin
        m_axis_tready <= 1'b1;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall = idle_len();
      end
    end
  end

  // result words are checked at the edge that takes them
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      polygon_sb.check_inside(m_axis_tdata[0]);
      results_seen++;
    end
  end

  // run limit, counted in clock cycles
  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_cnt, polygon_sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    polygon_sb    = new();
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = pic_pkg::OP_WRITE;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = pic_pkg::REG_POS_X;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    while (items_sent < ITEM_TARGET) run_phase();
    settle_block();

    $display("ran %0d words: %0d vertex writes, %0d queries (%0d inside) over %0d setups",
             items_sent, n_writes, polygon_sb.n_queries, polygon_sb.n_inside, n_setups);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             n_reg_writes, polygon_sb.n_results, polygon_sb.n_errors);
    if (polygon_sb.n_errors == 0 && polygon_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (polygon_sb.pending() != 0)
        $display("%0d expected results never arrived", polygon_sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pic_pkg.sv
sv/pic_vtx_mem.sv
sv/pic_xprod_unit.sv
sv/point_in_convex_polygon_top.sv
tb/sv/tb_point_in_convex_polygon_top.sv
